// ===== rtl/met_pkg.sv =====
// Shared constants for the Mandelbrot escape-time core.
`default_nettype none
package met_pkg;

  // Q4.44 fixed point, 48-bit two's complement
  localparam int Q_W    = 48;
  localparam int FRAC_W = 44;
  localparam int PROD_W = 2 * Q_W;

  // pixel position and count fields
  localparam int POS_W      = 10;
  localparam int MAX_ITER   = 512;
  localparam int CNT_BITS   = $clog2(MAX_ITER + 1);
  localparam int CNT_W      = (CNT_BITS > POS_W) ? CNT_BITS : POS_W;

  // 4.0 in Q4.44
  localparam logic [Q_W-1:0] FOUR_Q = Q_W'(4) << FRAC_W;

  // configuration register map
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_X_MIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_STEP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Y_MIN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_STEP = 2'd3;

  // register reset values
  localparam logic [Q_W-1:0] X_MIN_RST  = Q_W'(-64'sd35360293949276);
  localparam logic [Q_W-1:0] X_STEP_RST = Q_W'(64'sd51711406244);
  localparam logic [Q_W-1:0] Y_MIN_RST  = Q_W'(-64'sd21110623253299);
  localparam logic [Q_W-1:0] Y_STEP_RST = Q_W'(64'sd56294995342);

  // multiplier split: operands cut in two halves
  localparam int HALF_W = Q_W / 2;

endpackage
`default_nettype wire

// ===== rtl/met_mul.sv =====
// Iterative signed 48x48 multiplier built on one 25x25 multiplier.
`default_nettype none
module met_mul (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [met_pkg::Q_W-1:0]      a,
  input  wire logic [met_pkg::Q_W-1:0]      b,
  output logic                              done,
  output logic [met_pkg::PROD_W-1:0]        prod
);
  import met_pkg::*;

  localparam int PP_W = 2 * (HALF_W + 1);

  logic                     run;
  logic [2:0]               cnt;
  logic [1:0]               idx;
  logic signed [HALF_W:0]   opa;
  logic signed [HALF_W:0]   opb;
  logic signed [PP_W-1:0]   pp;
  logic signed [PP_W-1:0]   preg;
  logic [1:0]               psh;
  logic signed [PROD_W-1:0] pext;
  logic signed [PROD_W-1:0] term;
  logic signed [PROD_W-1:0] acc;

  // partial order: lo*lo, lo*hi, hi*lo, hi*hi
  assign idx = start ? 2'd0 : cnt[1:0];
  assign opa = idx[1] ? $signed({a[Q_W-1], a[Q_W-1:HALF_W]})
                      : $signed({1'b0, a[HALF_W-1:0]});
  assign opb = idx[0] ? $signed({b[Q_W-1], b[Q_W-1:HALF_W]})
                      : $signed({1'b0, b[HALF_W-1:0]});
  assign pp  = opa * opb;

  assign pext = {{(PROD_W-PP_W){preg[PP_W-1]}}, preg};

  always_comb begin
    case (psh)
      2'd0:    term = pext;
      2'd1:    term = pext <<< HALF_W;
      2'd2:    term = pext <<< Q_W;
      default: term = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= 3'd1;
      end else if (run) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'd4) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc  <= '0;
      preg <= pp;
      psh  <= {1'b0, idx[0]} + {1'b0, idx[1]};
    end else if (run) begin
      acc <= acc + term;
      if (cnt != 3'd4) begin
        preg <= pp;
        psh  <= {1'b0, idx[0]} + {1'b0, idx[1]};
      end
    end
  end

  assign prod = acc;

endmodule
`default_nettype wire

// ===== rtl/mandelbrot_escape_time_core.sv =====
// Top level of the Mandelbrot escape-time core: sequencer, registers, stream ports.
//
// Usage:
//   s_* stream: one transfer per pixel, s_tdata = {row, col} (col in the low bits).
//   m_* stream: one transfer per pixel, m_tdata = {escape_count, row, col}.
//   cfg_* port: writes x_min, x_step, y_min, y_step (Q4.44) by index; always
//     ready; write only while no pixel is in flight. Indexes map 0..3 in order.
// Operation:
//   The pixel maps to c = (x_min + col*x_step, y_min + row*y_step), then
//   z = z*z + c is iterated from z = 0 until |z|^2 >= 4 or the count hits
//   MAX_ITER. All products go through one iterative 48x48 multiplier
//   (four 25x25 partial products per product).
// Steps:
//   A pixel runs the two coordinate products, then per iteration three
//   products plus the escape test, then a finishing step.
//   s_tready is high only while the sequencer is idle; one pixel at a time.
// Reset: rst (synchronous) empties the pipeline, drops m_tvalid and restores
//   the register reset values.
// Stall: a result waits in the output register; the next pixel may be taken
//   and computed meanwhile, and it waits at its end until the register frees.
`default_nettype none
module mandelbrot_escape_time_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // input pixel
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [23:0]                     s_tdata,   // col[9:0], row[19:10]
  // result
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [31:0]                          m_tdata,   // out_col[9:0], out_row[19:10],
                                                          // escape_count[29:20]
  // configuration writes
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [met_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [met_pkg::Q_W-1:0]         cfg_data
);
  import met_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_CX   = 8'b0000_0010,
    ST_CY   = 8'b0000_0100,
    ST_TEST = 8'b0000_1000,
    ST_SQX  = 8'b0001_0000,
    ST_SQY  = 8'b0010_0000,
    ST_MXY  = 8'b0100_0000,
    ST_DONE = 8'b1000_0000
  } state_t;

  state_t state;

  // configuration registers
  logic [Q_W-1:0] x_min, x_step, y_min, y_step;

  // pixel working registers
  logic [POS_W-1:0] col, row;
  logic [Q_W-1:0]   cx, cy, x, y, xs, ys;
  logic [CNT_W-1:0] count;

  // multiplier interface
  logic                mul_start;
  logic [Q_W-1:0]      mul_a, mul_b;
  logic                mul_done;
  logic [PROD_W-1:0]   mul_prod;
  logic [Q_W-1:0]      prod_int;   // integer product, wrapped
  logic [Q_W-1:0]      prod_q;     // Q4.44 product, floored and wrapped

  logic [Q_W-1:0] mag2;
  logic           escaped;
  logic           out_free;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign out_free  = !m_tvalid || m_tready;

  assign prod_int = mul_prod[Q_W-1:0];
  assign prod_q   = mul_prod[FRAC_W+Q_W-1:FRAC_W];

  // wrapped sum read as signed; a negative reading never escapes
  assign mag2    = xs + ys;
  assign escaped = !mag2[Q_W-1] && (mag2 >= FOUR_Q);

  met_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // configuration register file
  always_ff @(posedge clk) begin
    if (rst) begin
      x_min  <= X_MIN_RST;
      x_step <= X_STEP_RST;
      y_min  <= Y_MIN_RST;
      y_step <= Y_STEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_X_MIN:  x_min  <= cfg_data;
        REG_X_STEP: x_step <= cfg_data;
        REG_Y_MIN:  y_min  <= cfg_data;
        REG_Y_STEP: y_step <= cfg_data;
        default:    ;
      endcase
    end
  end

  // sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      mul_start <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      mul_start <= 1'b0;
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            mul_start <= 1'b1;
            state     <= ST_CX;
          end
        end
        ST_CX: begin
          if (mul_done) begin
            mul_start <= 1'b1;
            state     <= ST_CY;
          end
        end
        ST_CY: begin
          if (mul_done) begin
            state <= ST_TEST;
          end
        end
        ST_TEST: begin
          if ((count >= CNT_W'(MAX_ITER)) || escaped) begin
            state <= ST_DONE;
          end else begin
            mul_start <= 1'b1;
            state     <= ST_SQX;
          end
        end
        ST_SQX: begin
          if (mul_done) begin
            mul_start <= 1'b1;
            state     <= ST_SQY;
          end
        end
        ST_SQY: begin
          if (mul_done) begin
            mul_start <= 1'b1;
            state     <= ST_MXY;
          end
        end
        ST_MXY: begin
          if (mul_done) begin
            state <= ST_TEST;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        col   <= s_tdata[POS_W-1:0];
        row   <= s_tdata[2*POS_W-1:POS_W];
        mul_a <= {{(Q_W-POS_W){1'b0}}, s_tdata[POS_W-1:0]};
        mul_b <= x_step;
      end
      ST_CX: begin
        if (mul_done) begin
          cx    <= x_min + prod_int;
          mul_a <= {{(Q_W-POS_W){1'b0}}, row};
          mul_b <= y_step;
        end
      end
      ST_CY: begin
        if (mul_done) begin
          cy    <= y_min + prod_int;
          x     <= '0;
          y     <= '0;
          xs    <= '0;
          ys    <= '0;
          count <= CNT_W'(1);
        end
      end
      ST_TEST: begin
        mul_a <= x;
        mul_b <= x;
      end
      ST_SQX: begin
        if (mul_done) begin
          xs    <= prod_q;
          mul_a <= y;
          mul_b <= y;
        end
      end
      ST_SQY: begin
        if (mul_done) begin
          ys    <= prod_q;
          mul_a <= y;
          mul_b <= x;
        end
      end
      ST_MXY: begin
        if (mul_done) begin
          y     <= {prod_q[Q_W-2:0], 1'b0} + cy;
          x     <= xs - ys + cx;
          count <= count + CNT_W'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          m_tdata <= {2'b00, count[POS_W-1:0], row, col};
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== tb/tb_mandelbrot_escape_time_core.sv =====
// Self-checking testbench for the Mandelbrot escape-time core: directed and random views.
module tb_mandelbrot_escape_time_core;
  timeunit 1ns;
  timeprecision 1ps;

  import met_pkg::*;

  // Q4.44 constants used to lay out views
  localparam longint Q_ONE = longint'(1) << FRAC_W;
  localparam longint Q_MAX = (longint'(1) << (Q_W - 1)) - 1;
  localparam longint Q_MIN = -(longint'(1) << (Q_W - 1));

  // watchdog limit on cycles with no transfer at all
  localparam int QUIET_LIMIT  = 40000;
  localparam int DRAIN_CYCLES = 8;
  localparam int TAIL_CYCLES  = 200;
  localparam int GAP_PCT      = 19;

  typedef struct {
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic [CNT_W-1:0] count;
  } pixel_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // pixel stream in: tdata = {4'b0, row, col}
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata  = '0;
  // result stream out: tdata = {2'b0, escape_count, row, col}
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  // register write channel
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_X_MIN;
  logic [Q_W-1:0]       cfg_data  = '0;

  // local copy of the view registers, starting from the reset values
  logic [Q_W-1:0] view_x_min  = X_MIN_RST;
  logic [Q_W-1:0] view_x_step = X_STEP_RST;
  logic [Q_W-1:0] view_y_min  = Y_MIN_RST;
  logic [Q_W-1:0] view_y_step = Y_STEP_RST;

  pixel_result_t pending_pixels[$];
  int            mismatches   = 0;
  int            quiet_cycles = 0;
  bit            traffic_gaps = 1'b1;   // random idling on both streams

  mandelbrot_escape_time_core u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Escape-time prediction
  // ---------------------------------------------------------------------------

  // Q4.44 product: exact 96-bit signed product, floor shift by 44, wrap to 48
  function automatic logic [Q_W-1:0] fx_mul(input logic [Q_W-1:0] a, input logic [Q_W-1:0] b);
    logic signed [PROD_W-1:0] ea;
    logic signed [PROD_W-1:0] eb;
    logic signed [PROD_W-1:0] p;
    ea = {{Q_W{a[Q_W-1]}}, a};
    eb = {{Q_W{b[Q_W-1]}}, b};
    p  = ea * eb;
    return p[FRAC_W +: Q_W];
  endfunction

  function automatic logic [CNT_W-1:0] predict_count(input logic [POS_W-1:0] col,
                                                     input logic [POS_W-1:0] row);
    logic [Q_W-1:0] cx;
    logic [Q_W-1:0] cy;
    logic [Q_W-1:0] x;
    logic [Q_W-1:0] y;
    logic [Q_W-1:0] xs;
    logic [Q_W-1:0] ys;
    logic [Q_W-1:0] xy;
    logic [Q_W-1:0] mag;
    int unsigned    n;
    // direct products, 48-bit wrap
    cx  = view_x_min + Q_W'(col) * view_x_step;
    cy  = view_y_min + Q_W'(row) * view_y_step;
    x   = '0;
    y   = '0;
    mag = '0;
    n   = 1;
    // escape test uses the squares of the previous pass; a wrapped sum that
    // reads negative never escapes
    while (n < MAX_ITER && (mag[Q_W-1] || mag < FOUR_Q)) begin
      xs  = fx_mul(x, x);
      ys  = fx_mul(y, y);
      xy  = fx_mul(y, x);
      y   = xy + xy + cy;
      x   = xs - ys + cx;
      mag = xs + ys;
      n++;
    end
    return n[CNT_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker and receiver back-pressure
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    pixel_result_t want;
    logic [POS_W-1:0] got_col;
    logic [POS_W-1:0] got_row;
    logic [CNT_W-1:0] got_count;
    if (!rst && m_tvalid && m_tready) begin
      got_col   = m_tdata[0 +: POS_W];
      got_row   = m_tdata[POS_W +: POS_W];
      got_count = m_tdata[2*POS_W +: CNT_W];
      if (pending_pixels.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: result with nothing expected: col %0d row %0d count %0d",
                   $realtime, got_col, got_row, got_count);
        mismatches++;
      end else begin
        want = pending_pixels.pop_front();
        if (got_col !== want.col || got_row !== want.row || got_count !== want.count) begin
          if (mismatches < 10)
            $display("%0t: expected col %0d row %0d count %0d, got col %0d row %0d count %0d",
                     $realtime, want.col, want.row, want.count, got_col, got_row, got_count);
          mismatches++;
        end
      end
    end
    m_tready <= !traffic_gaps || ($urandom_range(99) >= GAP_PCT);
  end

  // ---------------------------------------------------------------------------
  // Watchdog: any transfer on any channel counts as progress
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_mandelbrot_escape_time_core failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic longint rand_q(input longint lo, input longint span);
    longint unsigned r;
    r = {$urandom, $urandom};
    return lo + longint'(r % longint'(span));
  endfunction

  // Send one pixel; tvalid is left high so back-to-back transfers need no
  // second assignment in the same step. Expectation is queued on acceptance.
  task automatic send_pixel(input logic [POS_W-1:0] col, input logic [POS_W-1:0] row);
    pixel_result_t want;
    if (traffic_gaps && $urandom_range(99) < GAP_PCT) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 24'($urandom);    // junk while idle
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, row, col};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    want.col   = col;
    want.row   = row;
    want.count = predict_count(col, row);
    pending_pixels.push_back(want);
  endtask

  // Sender holds off until every expected result has been taken.
  task automatic wait_results_done();
    s_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all four view registers in index order; only called while idle.
  task automatic set_view(input logic [Q_W-1:0] x_min, input logic [Q_W-1:0] x_step,
                          input logic [Q_W-1:0] y_min, input logic [Q_W-1:0] y_step);
    logic [Q_W-1:0] vals[4];
    vals = '{x_min, x_step, y_min, y_step};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (CFG_IDX_W'(i))
        REG_X_MIN:  view_x_min  = vals[i];
        REG_X_STEP: view_x_step = vals[i];
        REG_Y_MIN:  view_y_min  = vals[i];
        REG_Y_STEP: view_y_step = vals[i];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_pixels(input int n);
    for (int i = 0; i < n; i++)
      send_pixel(POS_W'($urandom), POS_W'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset view: corners, alternating bit patterns, a point inside the set.
  task automatic test_reset_view();
    send_pixel(10'd0,    10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd0,    10'd1023);
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'd515,  10'd375);   // c ~ -0.5 + 0i, never escapes
    send_pixel(10'h2AA,  10'h155);
    send_pixel(10'h155,  10'h2AA);
    send_pixel(10'd400,  10'd300);
    wait_results_done();
  endtask

  // Register extremes, c = 0, quick escape, and wrapped squares.
  task automatic test_extreme_views();
    set_view(Q_W'(Q_MAX), Q_W'(Q_MIN), Q_W'(Q_MIN), Q_W'(Q_MAX));
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1, 10'd1);
    send_pixel(10'd1023, 10'd1023);
    wait_results_done();
    set_view(Q_W'(Q_MIN), Q_W'(Q_MAX), Q_W'(Q_MAX), Q_W'(Q_MIN));
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1);
    send_pixel(10'd512, 10'd512);
    wait_results_done();
    // origin: runs to the iteration limit
    set_view('0, '0, '0, '0);
    send_pixel(10'd5, 10'd7);
    wait_results_done();
    // c = 2.5: escapes on the earliest possible test
    set_view(Q_W'((5 * Q_ONE) / 2), '0, '0, '0);
    send_pixel(10'd9, 10'd3);
    wait_results_done();
    // c = 2.9: square wraps past 8 and the sum reads negative
    set_view(Q_W'((29 * Q_ONE) / 10), '0, '0, '0);
    send_pixel(10'd100, 10'd200);
    wait_results_done();
    // c near the top of the format
    set_view(Q_W'((79 * Q_ONE) / 10), '0, Q_W'(-(79 * Q_ONE) / 10), '0);
    send_pixel(10'd1023, 10'd0);
    wait_results_done();
  endtask

  // Whole-set views: mix of short, medium and full-length counts.
  task automatic test_wide_views();
    for (int p = 0; p < 3; p++) begin
      set_view(Q_W'(rand_q(-(5 * Q_ONE) / 2, Q_ONE)), Q_W'(rand_q(Q_ONE >> 9, Q_ONE >> 9)),
               Q_W'(rand_q(-2 * Q_ONE, Q_ONE)), Q_W'(rand_q(Q_ONE >> 9, Q_ONE >> 9)));
      send_random_pixels(100);
      wait_results_done();
    end
  endtask

  // Views beyond |y| = 2: cheap pixels, the bulk of the traffic. One phase
  // runs with no idling on either side.
  task automatic test_outer_views();
    longint ymin;
    longint ystep;
    for (int p = 0; p < 6; p++) begin
      ymin  = rand_q((21 * Q_ONE) / 10, Q_ONE / 2);
      ystep = rand_q(0, Q_ONE >> 11);
      if ($urandom_range(1)) begin
        ymin  = -ymin;
        ystep = -ystep;
      end
      traffic_gaps = (p != 2);
      set_view(Q_W'(rand_q(-Q_ONE, Q_ONE / 2)), Q_W'(rand_q(0, Q_ONE >> 11)),
               Q_W'(ymin), Q_W'(ystep));
      send_random_pixels(105);
      wait_results_done();
    end
    traffic_gaps = 1'b1;
  endtask

  // Tiny window near the cardioid neck: long counts, so kept short.
  task automatic test_boundary_zoom();
    set_view(Q_W'(rand_q(-(8 * Q_ONE) / 10, Q_ONE / 10)), Q_W'(rand_q(1, Q_ONE >> 16)),
             Q_W'(rand_q(0, Q_ONE / 10)), Q_W'(rand_q(1, Q_ONE >> 16)));
    send_random_pixels(30);
    wait_results_done();
  endtask

  // Fully random register contents: heavy wrapping everywhere.
  task automatic test_random_registers();
    for (int p = 0; p < 3; p++) begin
      set_view(Q_W'({$urandom, $urandom}), Q_W'({$urandom, $urandom}),
               Q_W'({$urandom, $urandom}), Q_W'({$urandom, $urandom}));
      send_random_pixels(20);
      wait_results_done();
    end
  endtask

  // Mirrored views with negative steps.
  task automatic test_flipped_views();
    for (int p = 0; p < 2; p++) begin
      set_view(Q_W'(rand_q(Q_ONE / 2, Q_ONE)), Q_W'(rand_q(-(Q_ONE >> 8), Q_ONE >> 9)),
               Q_W'(rand_q(Q_ONE, Q_ONE)), Q_W'(rand_q(-(Q_ONE >> 8), Q_ONE >> 9)));
      send_random_pixels(70);
      wait_results_done();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_view();
    test_extreme_views();
    test_wide_views();
    test_outer_views();
    test_boundary_zoom();
    test_random_registers();
    test_flipped_views();

    wait_results_done();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("tb_mandelbrot_escape_time_core passed");
    end else begin
      $display("tb_mandelbrot_escape_time_core failed");
    end
    $finish;
  end

endmodule
